>>> src/sqm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqm_pkg
// Shared types and constants of the set-associative queue mapper.
// ----------------------------------------------------------------------------
package sqm_pkg;

    localparam int MAX_QUEUES = 1024;
    localparam int MAX_WAYS   = 64;

    localparam int HASH_W = 32;
    localparam int QA_W   = $clog2(MAX_QUEUES);
    localparam int WAY_W  = QA_W + 1;
    localparam int NQ_W   = 11;
    localparam int SW_W   = 7;
    localparam int KC_W   = $clog2(MAX_WAYS);
    localparam int DCNT_W = $clog2(HASH_W);
    localparam int CMD_W  = 2;
    localparam int SEL_W  = 10;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_QUEUES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SET_WAYS   = 2'd1;

    localparam logic [NQ_W-1:0] NUM_QUEUES_RESET = 11'd1024;
    localparam logic [SW_W-1:0] SET_WAYS_RESET   = 7'd8;

    localparam logic [CMD_W-1:0] CMD_LOOKUP     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACTIVATE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEACTIVATE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [HASH_W-1:0] flow_hash;
        logic [SEL_W-1:0]  queue_sel;
    } t_in_word;

    typedef struct packed {
        logic [SEL_W-1:0] queue_index;
        logic             evicted;
    } t_out_word;

    typedef struct packed {
        logic              active;
        logic              used;
        logic [HASH_W-1:0] tag;
    } t_entry;

    localparam int ENT_W = $bits(t_entry);

endpackage

>>> src/set_associative_queue_mapper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_associative_queue_mapper_top
// Maps a flow hash to a queue through a set-associative table held in one RAM.
// Lookup: hash remainder, then set remainder, then one way per cycle.
// Throughput: one word at a time; the next word is taken once a result is staged.
// Reset: synchronous; a clearing pass over every RAM entry runs, input stalled.
// ----------------------------------------------------------------------------
module set_associative_queue_mapper_top
    import sqm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_word              i_in_word,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_word             o_out_word,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DIV1 = 4'd2;
    localparam logic [3:0] S_DIV2 = 4'd3;
    localparam logic [3:0] S_BASE = 4'd4;
    localparam logic [3:0] S_SCAN = 4'd5;
    localparam logic [3:0] S_STWR = 4'd6;
    localparam logic [3:0] S_WAIT = 4'd7;

    logic [3:0]        r_state, n_state;
    logic [QA_W-1:0]   r_clr, n_clr;
    logic [NQ_W-1:0]   r_nq;
    logic [SW_W-1:0]   r_sw;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [HASH_W-1:0] r_hash, n_hash;
    logic [SEL_W-1:0]  r_sel, n_sel;
    logic [HASH_W-1:0] r_dvd, n_dvd;
    logic [QA_W-1:0]   r_rem, n_rem;
    logic [NQ_W-1:0]   r_div, n_div;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic [QA_W-1:0]   r_h, n_h;
    logic [SW_W-1:0]   r_ways, n_ways;
    logic [QA_W-1:0]   r_base, n_base;
    logic [WAY_W-1:0]  r_way, n_way;
    logic [KC_W-1:0]   r_k, n_k;
    logic              r_base_act, n_base_act;
    t_out_word         r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out_word, n_out_word;

    logic [NQ_W-1:0]   eff_q;
    logic [SW_W-1:0]   eff_w;
    logic [NQ_W-1:0]   dv_t, dv_r;
    logic [QA_W-1:0]   dv_new;
    logic [QA_W-1:0]   base_calc;
    logic              way_oob, way_free, way_last, base_act_now;

    logic              ram_we;
    logic [QA_W-1:0]   ram_waddr, ram_raddr;
    t_entry            ram_wdata, rd;

    sqm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_QUEUES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        if (r_nq == '0) begin
            eff_q = NQ_W'(1);
        end else if (r_nq > NQ_W'(MAX_QUEUES)) begin
            eff_q = NQ_W'(MAX_QUEUES);
        end else begin
            eff_q = r_nq;
        end
        if (r_sw == '0) begin
            eff_w = SW_W'(1);
        end else if (r_sw > SW_W'(MAX_WAYS)) begin
            eff_w = SW_W'(MAX_WAYS);
        end else begin
            eff_w = r_sw;
        end
    end

    // one restoring remainder step per cycle
    assign dv_t      = {r_rem, r_dvd[HASH_W-1]};
    assign dv_r      = (dv_t >= r_div) ? (dv_t - r_div) : dv_t;
    assign dv_new    = dv_r[QA_W-1:0];
    assign base_calc = r_h - dv_new;

    assign way_oob      = (r_way >= WAY_W'(MAX_QUEUES));
    assign way_free     = way_oob || !rd.used || (rd.tag == r_hash) || !rd.active;
    assign way_last     = (SW_W'(r_k) == (r_ways - SW_W'(1)));
    assign base_act_now = (r_k == '0) ? rd.active : r_base_act;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cmd       = r_cmd;
        n_hash      = r_hash;
        n_sel       = r_sel;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_div       = r_div;
        n_cnt       = r_cnt;
        n_h         = r_h;
        n_ways      = r_ways;
        n_base      = r_base;
        n_way       = r_way;
        n_k         = r_k;
        n_base_act  = r_base_act;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        ram_we      = 1'b0;
        ram_waddr   = r_clr;
        ram_wdata   = '0;
        ram_raddr   = r_way[QA_W-1:0];

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + QA_W'(1);
                if (r_clr == QA_W'(MAX_QUEUES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ram_raddr = i_in_word.queue_sel;
                if (i_in_valid) begin
                    n_cmd  = i_in_word.command;
                    n_hash = i_in_word.flow_hash;
                    n_sel  = i_in_word.queue_sel;
                    n_dvd  = i_in_word.flow_hash;
                    n_rem  = '0;
                    n_div  = eff_q;
                    n_cnt  = DCNT_W'(HASH_W - 1);
                    n_ways = eff_w;
                    case (i_in_word.command)
                        CMD_LOOKUP: begin
                            n_state = S_DIV1;
                        end
                        CMD_ACTIVATE, CMD_DEACTIVATE: begin
                            n_state = S_STWR;
                        end
                        default: begin
                            n_res.queue_index = i_in_word.queue_sel;
                            n_res.evicted     = 1'b0;
                            n_state           = S_WAIT;
                        end
                    endcase
                end
            end
            S_DIV1: begin
                n_rem = dv_new;
                n_dvd = r_dvd << 1;
                n_cnt = r_cnt - DCNT_W'(1);
                if (r_cnt == '0) begin
                    n_h     = dv_new;
                    n_dvd   = {dv_new, (HASH_W - QA_W)'(0)};
                    n_rem   = '0;
                    n_div   = NQ_W'(r_ways);
                    n_cnt   = DCNT_W'(QA_W - 1);
                    n_state = S_DIV2;
                end
            end
            S_DIV2: begin
                n_rem = dv_new;
                n_dvd = r_dvd << 1;
                n_cnt = r_cnt - DCNT_W'(1);
                if (r_cnt == '0) begin
                    n_base  = base_calc;
                    n_way   = {1'b0, base_calc};
                    n_k     = '0;
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                ram_raddr = r_way[QA_W-1:0];
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                ram_raddr = r_way[QA_W-1:0] + QA_W'(1);
                if (r_k == '0) begin
                    n_base_act = rd.active;
                end
                if (way_free) begin
                    if (!way_oob) begin
                        ram_we           = 1'b1;
                        ram_waddr        = r_way[QA_W-1:0];
                        ram_wdata.active = rd.active;
                        ram_wdata.used   = 1'b1;
                        ram_wdata.tag    = r_hash;
                    end
                    n_res.queue_index = r_way[QA_W-1:0];
                    n_res.evicted     = 1'b0;
                    n_state           = S_WAIT;
                end else if (way_last) begin
                    ram_we            = 1'b1;
                    ram_waddr         = r_base;
                    ram_wdata.active  = base_act_now;
                    ram_wdata.used    = 1'b1;
                    ram_wdata.tag     = r_hash;
                    n_res.queue_index = r_base;
                    n_res.evicted     = 1'b1;
                    n_state           = S_WAIT;
                end else begin
                    n_k   = r_k + KC_W'(1);
                    n_way = r_way + WAY_W'(1);
                end
            end
            S_STWR: begin
                ram_we            = 1'b1;
                ram_waddr         = r_sel;
                ram_wdata.active  = (r_cmd == CMD_ACTIVATE);
                ram_wdata.used    = rd.used;
                ram_wdata.tag     = rd.tag;
                n_res.queue_index = r_sel;
                n_res.evicted     = 1'b0;
                n_state           = S_WAIT;
            end
            S_WAIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_nq        <= NUM_QUEUES_RESET;
            r_sw        <= SET_WAYS_RESET;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_NUM_QUEUES: begin
                        r_nq <= i_cfg_data[NQ_W-1:0];
                    end
                    REG_SET_WAYS: begin
                        r_sw <= i_cfg_data[SW_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_hash     <= n_hash;
        r_sel      <= n_sel;
        r_dvd      <= n_dvd;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_cnt      <= n_cnt;
        r_h        <= n_h;
        r_ways     <= n_ways;
        r_base     <= n_base;
        r_way      <= n_way;
        r_k        <= n_k;
        r_base_act <= n_base_act;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

endmodule

>>> src/sqm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
